[design/x86_subset_insn_decoder_defines.svh]
// Assertion macros used by the decoder's top-level RTL file.
`ifndef X86_SUBSET_INSN_DECODER_DEFINES_SVH
`define X86_SUBSET_INSN_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while in reset.
`define XSID_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("decoder assertion failed");

// Next-cycle implication, sampled on clk and held off while in reset.
`define XSID_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("decoder assertion failed");

`endif

[design/xsid_pkg.sv]
// Package with the decoder's result type, opcode values and output codes.
package xsid_pkg;

	localparam logic [3:0] KIND_UNKNOWN = 4'd0;
	localparam logic [3:0] KIND_NOP     = 4'd1;
	localparam logic [3:0] KIND_INT3    = 4'd2;
	localparam logic [3:0] KIND_RET     = 4'd3;
	localparam logic [3:0] KIND_PUSH    = 4'd4;
	localparam logic [3:0] KIND_POP     = 4'd5;
	localparam logic [3:0] KIND_CALL    = 4'd6;
	localparam logic [3:0] KIND_JMP     = 4'd7;
	localparam logic [3:0] KIND_JCC     = 4'd8;
	localparam logic [3:0] KIND_MOV     = 4'd9;
	localparam logic [3:0] KIND_CMP     = 4'd10;
	localparam logic [3:0] KIND_TEST    = 4'd11;
	localparam logic [3:0] KIND_MOVZX   = 4'd12;

	localparam logic [3:0] FORM_NONE      = 4'd0;
	localparam logic [3:0] FORM_REG       = 4'd1;
	localparam logic [3:0] FORM_IMM       = 4'd2;
	localparam logic [3:0] FORM_REL       = 4'd3;
	localparam logic [3:0] FORM_ABS_MEM   = 4'd4;
	localparam logic [3:0] FORM_OTHER_MEM = 4'd5;
	localparam logic [3:0] FORM_REG_DISP8 = 4'd6;
	localparam logic [3:0] FORM_REG_DISP32 = 4'd7;
	localparam logic [3:0] FORM_REG_REG   = 4'd8;
	localparam logic [3:0] FORM_REG_IMM   = 4'd9;

	localparam logic [2:0] HINT_NONE    = 3'd0;
	localparam logic [2:0] HINT_INDEX   = 3'd1;
	localparam logic [2:0] HINT_COUNT   = 3'd2;
	localparam logic [2:0] HINT_HANDLER = 3'd3;
	localparam logic [2:0] HINT_SIZE    = 3'd4;
	localparam logic [2:0] HINT_CMP_IDX = 3'd5;

	localparam logic [7:0] OP_NOP      = 8'h90;
	localparam logic [7:0] OP_INT3     = 8'hCC;
	localparam logic [7:0] OP_RET      = 8'hC3;
	localparam logic [7:0] OP_RET_IMM  = 8'hC2;
	localparam logic [7:0] OP_PUSH_I32 = 8'h68;
	localparam logic [7:0] OP_PUSH_I8  = 8'h6A;
	localparam logic [7:0] OP_CALL_REL = 8'hE8;
	localparam logic [7:0] OP_JMP_REL  = 8'hE9;
	localparam logic [7:0] OP_JMP_SHORT = 8'hEB;
	localparam logic [7:0] OP_ESCAPE   = 8'h0F;
	localparam logic [7:0] OP_GRP5     = 8'hFF;
	localparam logic [7:0] OP_GRP1_B   = 8'h80;
	localparam logic [7:0] OP_GRP1_S   = 8'h83;
	localparam logic [7:0] OP_CMP_EAX  = 8'h3D;
	localparam logic [7:0] OP_TEST_AL  = 8'hA8;
	localparam logic [7:0] OP_TEST_RR  = 8'h85;
	localparam logic [7:0] OP_MOV_LOAD = 8'h8B;
	localparam logic [7:0] OP2_MOVZX_B = 8'hB6;
	localparam logic [7:0] OP2_MOVZX_W = 8'hB7;

	localparam logic [7:0] DISP_INDEX   = 8'h68;
	localparam logic [7:0] DISP_NEAR    = 8'h6A;
	localparam logic [7:0] DISP_COUNT   = 8'h6B;
	localparam logic [7:0] DISP_SIZE    = 8'h6C;
	localparam logic [7:0] DISP_HANDLER = 8'h70;

	localparam logic [31:0] TABLE_SPAN = 32'd16384;

	typedef struct packed {
		logic [3:0]  insn_length;
		logic [3:0]  insn_kind;
		logic [3:0]  cond_code;
		logic [2:0]  first_reg;
		logic [2:0]  second_reg;
		logic [3:0]  operand_form;
		logic [31:0] imm_value;
		logic [31:0] branch_target;
		logic        short_jump;
		logic        word_access;
		logic        table_hit;
		logic [2:0]  field_hint;
	} dec_res_t;

endpackage

[design/xsid_if.sv]
// Valid/ready channel interfaces for instructions, decode results and configuration.
interface xsid_insn_if;
	logic        valid;
	logic        ready;
	logic [63:0] code_bytes;
	logic [31:0] insn_address;

	modport source (output valid, output code_bytes, output insn_address, input ready);
	modport sink (input valid, input code_bytes, input insn_address, output ready);
endinterface

interface xsid_dec_if;
	logic        valid;
	logic        ready;
	logic [3:0]  insn_length;
	logic [3:0]  insn_kind;
	logic [3:0]  cond_code;
	logic [2:0]  first_reg;
	logic [2:0]  second_reg;
	logic [3:0]  operand_form;
	logic [31:0] imm_value;
	logic [31:0] branch_target;
	logic        short_jump;
	logic        word_access;
	logic        table_hit;
	logic [2:0]  field_hint;

	modport source (output valid, output insn_length, output insn_kind, output cond_code,
		output first_reg, output second_reg, output operand_form, output imm_value,
		output branch_target, output short_jump, output word_access, output table_hit,
		output field_hint, input ready);
	modport sink (input valid, input insn_length, input insn_kind, input cond_code,
		input first_reg, input second_reg, input operand_form, input imm_value,
		input branch_target, input short_jump, input word_access, input table_hit,
		input field_hint, output ready);
endinterface

interface xsid_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/xsid_decode.sv]
// Combinational decode of one instruction window into a result record.
module xsid_decode (
	input  logic [63:0]        code_bytes,
	input  logic [31:0]        insn_address,
	input  logic [31:0]        table_base,
	output xsid_pkg::dec_res_t res
);
	import xsid_pkg::*;

	logic [7:0]  b0, b1, b2, b3;
	logic [1:0]  mod1, mod2;
	logic [2:0]  reg1, rm1;
	logic [31:0] word1, word2, sext1, win_end;
	logic        win_hit1;

	// Extra bytes after the ModR/M byte, using the simplified length rule.
	function automatic logic [3:0] modrm_extra(input logic [7:0] m);
		logic [3:0] n;
		case (m[7:6])
			2'd3: n = 4'd0;
			2'd0: n = (m[2:0] == 3'd5) ? 4'd4 : ((m[2:0] == 3'd4) ? 4'd1 : 4'd0);
			2'd1: n = (m[2:0] == 3'd4) ? 4'd2 : 4'd1;
			default: n = (m[2:0] == 3'd4) ? 4'd5 : 4'd4;
		endcase
		return n;
	endfunction

	assign b0 = code_bytes[7:0];
	assign b1 = code_bytes[15:8];
	assign b2 = code_bytes[23:16];
	assign b3 = code_bytes[31:24];
	assign mod1 = b1[7:6];
	assign reg1 = b1[5:3];
	assign rm1 = b1[2:0];
	assign mod2 = b2[7:6];
	assign word1 = code_bytes[39:8];
	assign word2 = code_bytes[47:16];
	assign sext1 = {{24{b1[7]}}, b1};

	// The window end wraps, so a base near the top of the space never hits.
	assign win_end = table_base + TABLE_SPAN;
	assign win_hit1 = (table_base != 32'd0) && (word1 >= table_base) && (word1 < win_end);

	always_comb begin
		res = '0;
		res.insn_length = 4'd1;
		res.insn_kind = KIND_UNKNOWN;
		res.operand_form = FORM_NONE;
		res.field_hint = HINT_NONE;
		case (b0) inside
			OP_NOP: begin
				res.insn_kind = KIND_NOP;
			end
			OP_INT3: begin
				res.insn_kind = KIND_INT3;
			end
			OP_RET: begin
				res.insn_kind = KIND_RET;
			end
			OP_RET_IMM: begin
				res.insn_length = 4'd3;
				res.insn_kind = KIND_RET;
				res.operand_form = FORM_IMM;
				res.imm_value = {16'd0, b2, b1};
			end
			[8'h50:8'h57]: begin
				res.insn_kind = KIND_PUSH;
				res.operand_form = FORM_REG;
				res.first_reg = b0[2:0];
			end
			[8'h58:8'h5F]: begin
				res.insn_kind = KIND_POP;
				res.operand_form = FORM_REG;
				res.first_reg = b0[2:0];
			end
			OP_PUSH_I32: begin
				res.insn_length = 4'd5;
				res.insn_kind = KIND_PUSH;
				res.operand_form = FORM_IMM;
				res.imm_value = word1;
				res.table_hit = win_hit1;
			end
			OP_PUSH_I8: begin
				res.insn_length = 4'd2;
				res.insn_kind = KIND_PUSH;
				res.operand_form = FORM_IMM;
				res.imm_value = {24'd0, b1};
			end
			OP_CALL_REL, OP_JMP_REL: begin
				res.insn_length = 4'd5;
				res.insn_kind = (b0 == OP_CALL_REL) ? KIND_CALL : KIND_JMP;
				res.operand_form = FORM_REL;
				res.imm_value = word1;
				res.branch_target = insn_address + 32'd5 + word1;
			end
			OP_JMP_SHORT: begin
				res.insn_length = 4'd2;
				res.insn_kind = KIND_JMP;
				res.operand_form = FORM_REL;
				res.short_jump = 1'b1;
				res.imm_value = {24'd0, b1};
				res.branch_target = insn_address + 32'd2 + sext1;
			end
			[8'h70:8'h7F]: begin
				res.insn_length = 4'd2;
				res.insn_kind = KIND_JCC;
				res.cond_code = b0[3:0];
				res.operand_form = FORM_REL;
				res.imm_value = {24'd0, b1};
				res.branch_target = insn_address + 32'd2 + sext1;
			end
			OP_ESCAPE: begin
				if (b1[7:4] == 4'h8) begin
					res.insn_length = 4'd6;
					res.insn_kind = KIND_JCC;
					res.cond_code = b1[3:0];
					res.operand_form = FORM_REL;
					res.imm_value = word2;
					res.branch_target = insn_address + 32'd6 + word2;
				end else if (b1 == OP2_MOVZX_B || b1 == OP2_MOVZX_W) begin
					res.insn_length = 4'd3 + modrm_extra(b2);
					res.insn_kind = KIND_MOVZX;
					res.operand_form = FORM_OTHER_MEM;
					res.word_access = (b1 == OP2_MOVZX_W);
					res.first_reg = b2[5:3];
					if (mod2 == 2'd1) begin
						res.operand_form = FORM_REG_DISP8;
						res.second_reg = b2[2:0];
						res.imm_value = {24'd0, b3};
						if (b3 == DISP_INDEX) begin
							res.field_hint = HINT_INDEX;
						end else if (b3 == DISP_COUNT) begin
							res.field_hint = HINT_COUNT;
						end
					end
				end
			end
			OP_GRP5: begin
				if (reg1 == 3'd2 || reg1 == 3'd4 || reg1 == 3'd6) begin
					res.insn_length = 4'd2 + modrm_extra(b1);
					res.operand_form = FORM_OTHER_MEM;
					if (reg1 == 3'd2) begin
						res.insn_kind = KIND_CALL;
						if (mod1 == 2'd3) begin
							res.operand_form = FORM_REG;
							res.second_reg = rm1;
						end else if (mod1 == 2'd0 && rm1 == 3'd5) begin
							res.operand_form = FORM_ABS_MEM;
							res.imm_value = word2;
						end
					end else begin
						res.insn_kind = (reg1 == 3'd4) ? KIND_JMP : KIND_PUSH;
					end
				end
			end
			[8'hB8:8'hBF]: begin
				res.insn_length = 4'd5;
				res.insn_kind = KIND_MOV;
				res.operand_form = FORM_REG_IMM;
				res.first_reg = b0[2:0];
				res.imm_value = word1;
				res.table_hit = win_hit1;
			end
			OP_GRP1_B, OP_GRP1_S: begin
				if (reg1 == 3'd7) begin
					res.insn_length = 4'd3 + modrm_extra(b1);
					res.insn_kind = KIND_CMP;
					res.operand_form = FORM_OTHER_MEM;
					if (mod1 == 2'd1) begin
						res.operand_form = FORM_REG_DISP8;
						res.second_reg = rm1;
						res.imm_value = {24'd0, b2};
						if (b2 == DISP_INDEX || b2 == DISP_NEAR || b2 == DISP_COUNT) begin
							res.field_hint = HINT_CMP_IDX;
						end
					end
				end
			end
			OP_CMP_EAX: begin
				res.insn_length = 4'd5;
				res.insn_kind = KIND_CMP;
				res.operand_form = FORM_REG_IMM;
				res.imm_value = word1;
			end
			OP_TEST_AL: begin
				res.insn_length = 4'd2;
				res.insn_kind = KIND_TEST;
				res.operand_form = FORM_REG_IMM;
				res.imm_value = {24'd0, b1};
			end
			OP_TEST_RR: begin
				res.insn_length = 4'd2;
				res.insn_kind = KIND_TEST;
				res.operand_form = FORM_REG_REG;
				res.first_reg = reg1;
				res.second_reg = rm1;
			end
			OP_MOV_LOAD: begin
				res.insn_length = 4'd2 + modrm_extra(b1);
				res.insn_kind = KIND_MOV;
				res.first_reg = reg1;
				res.operand_form = FORM_OTHER_MEM;
				case (mod1)
					2'd1: begin
						res.operand_form = FORM_REG_DISP8;
						res.second_reg = rm1;
						res.imm_value = {24'd0, b2};
						if (b2 == DISP_HANDLER) begin
							res.field_hint = HINT_HANDLER;
						end else if (b2 == DISP_INDEX) begin
							res.field_hint = HINT_INDEX;
						end else if (b2 == DISP_SIZE) begin
							res.field_hint = HINT_SIZE;
						end
					end
					2'd2: begin
						res.operand_form = FORM_REG_DISP32;
						res.second_reg = rm1;
						res.imm_value = word2;
					end
					2'd3: begin
						res.operand_form = FORM_REG_REG;
						res.second_reg = rm1;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end
endmodule

[design/x86_subset_insn_decoder.sv]
// Top level of the subset x86 instruction decoder: pipeline, config register and checks.
//
//   channel | modport | transaction carries
//   --------+---------+---------------------------------------------------------
//   insn    | sink    | code_bytes (64), insn_address (32)
//   dec     | source  | length, kind, condition, registers, form, imm, target, flags
//   cfg     | sink    | data (32): table_base, the watched table window base
//
// One instruction is accepted per cycle while the dec channel keeps up. Each result
// is registered: the item passes the input register, then the single decode pass, then
// the result register, from which it is offered on the dec channel.
// A stalled dec channel holds its result; the input register still takes a new
// transaction while it is empty, or the result register is empty or being drained in the same cycle.
// Reset clears both valid flags and table_base; cfg is always ready.
module x86_subset_insn_decoder (
	input logic         clk,
	input logic         arst_n,
	xsid_insn_if.sink   insn,
	xsid_dec_if.source  dec,
	xsid_cfg_if.sink    cfg
);
	import xsid_pkg::*;

	`include "x86_subset_insn_decoder_defines.svh"

	logic        valid_s1, valid_s2;
	logic [63:0] code_s1;
	logic [31:0] addr_s1;
	logic [31:0] table_base_q;
	dec_res_t    res_d, res_s2;
	logic        move_s2, move_s1;

	// The result register loads whenever it is empty or its result leaves this
	// cycle; the input register loads whenever its item moves on or it is empty.
	assign move_s2 = !valid_s2 || dec.ready;
	assign move_s1 = !valid_s1 || move_s2;
	assign insn.ready = move_s1;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			table_base_q <= '0;
		end else begin
			if (move_s1) begin
				valid_s1 <= insn.valid;
			end
			if (move_s2) begin
				valid_s2 <= valid_s1;
			end
			if (cfg.valid) begin
				table_base_q <= cfg.data;
			end
		end
	end

	// Payload registers carry no reset; the valid flags qualify them.
	always_ff @(posedge clk) begin
		if (move_s1 && insn.valid) begin
			code_s1 <= insn.code_bytes;
			addr_s1 <= insn.insn_address;
		end
		if (move_s2 && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	// The whole decode, including the branch adder and window compare, sits
	// between the input register and the result register.
	xsid_decode u_decode (
		.code_bytes   (code_s1),
		.insn_address (addr_s1),
		.table_base   (table_base_q),
		.res          (res_d)
	);

	assign dec.valid = valid_s2;
	assign dec.insn_length = res_s2.insn_length;
	assign dec.insn_kind = res_s2.insn_kind;
	assign dec.cond_code = res_s2.cond_code;
	assign dec.first_reg = res_s2.first_reg;
	assign dec.second_reg = res_s2.second_reg;
	assign dec.operand_form = res_s2.operand_form;
	assign dec.imm_value = res_s2.imm_value;
	assign dec.branch_target = res_s2.branch_target;
	assign dec.short_jump = res_s2.short_jump;
	assign dec.word_access = res_s2.word_access;
	assign dec.table_hit = res_s2.table_hit;
	assign dec.field_hint = res_s2.field_hint;

	// No transaction is taken while both stages are full and the output stalls.
	`XSID_ASSERT_NOW(a_no_overrun, insn.valid && insn.ready, !(valid_s1 && valid_s2 && !dec.ready))
	// A result always reports a length of one to eight bytes.
	`XSID_ASSERT_NOW(a_len_range, dec.valid, dec.insn_length >= 4'd1 && dec.insn_length <= 4'd8)
	// Only relative call, jmp and jcc produce a branch target.
	`XSID_ASSERT_NOW(a_tgt_kind, dec.valid && dec.branch_target != 32'd0,
		dec.insn_kind == KIND_CALL || dec.insn_kind == KIND_JMP || dec.insn_kind == KIND_JCC)
	// The short jump flag belongs to the two-byte jmp alone.
	`XSID_ASSERT_NOW(a_short_jmp, dec.valid && dec.short_jump,
		dec.insn_kind == KIND_JMP && dec.insn_length == 4'd2)
	// A table hit needs a configured, nonzero window base.
	`XSID_ASSERT_NOW(a_hit_base, dec.valid && dec.table_hit, table_base_q != 32'd0)
	// An item in the input register reaches the result register on the next edge
	// when the output side is free.
	`XSID_ASSERT_NEXT(a_advance, valid_s1 && move_s2, valid_s2)
endmodule
